/* rtl/core/walsh_hadamard_transform_assert.svh */
// Assertion shorthands shared by the RTL of the transform block.
`ifndef WALSH_HADAMARD_TRANSFORM_ASSERT_SVH
`define WALSH_HADAMARD_TRANSFORM_ASSERT_SVH

// Same-cycle implication, checked out of reset only.
`define WHT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset only.
`define WHT_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/wht_pkg.sv */
`timescale 1ns / 1ps

package wht_pkg;

    // Sequencer states: collect samples, run butterflies, drain a stage, stream out.
    typedef enum logic [1:0] {
        ST_LOAD,
        ST_XFORM,
        ST_XGAP,
        ST_EMIT
    } t_state;

endpackage

/* rtl/core/wht_if.sv */
`timescale 1ns / 1ps

// Frame length write channel.
interface wht_cfg_if #(parameter int LEN_BITS = 7) ();
    logic                valid;
    logic                ready;
    logic [LEN_BITS-1:0] frame_length;

    modport source (output valid, output frame_length, input ready);
    modport sink   (input valid, input frame_length, output ready);
endinterface

// Sample input channel.
interface wht_smp_if #(parameter int SAMPLE_BITS = 16) ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

// Coefficient output channel.
interface wht_coef_if #(parameter int COEF_BITS = 22) ();
    logic                        valid;
    logic                        ready;
    logic signed [COEF_BITS-1:0] coefficient;
    logic                        last;

    modport source (output valid, output coefficient, output last, input ready);
    modport sink   (input valid, input coefficient, input last, output ready);
endinterface

/* rtl/core/wht_ram.sv */
`timescale 1ns / 1ps

// Simple dual-port RAM: one write port, one read port, read data registered.
module wht_ram #(
    parameter int WIDTH = 22,
    parameter int DEPTH = 32
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/walsh_hadamard_transform.sv */
`timescale 1ns / 1ps
// Fast Walsh-Hadamard transform over frames of signed samples.
// i_cfg  : frame_length write (1..SIZE; zero acts as one, larger saturates to SIZE).
//          Write only while idle; a write discards any partial frame.
// i_smp  : one sample per transfer, in frame order. Ready only while collecting.
// o_coef : frame_length coefficients per frame in natural Hadamard order, last
//          on the final one. Samples past the largest power of two P within the
//          frame length come out untouched.
// Timing : one sample per cycle while collecting; the transform then runs
//          stage by stage, P/2 butterflies per stage at one per cycle out
//          of two memory banks, plus a drain state per stage for the
//          read-modify-write turnaround; output streams at one coefficient
//          per cycle while o_coef.ready stays high.
// Reset  : frame_length returns to SIZE and the frame buffer counts as empty;
//          memory contents are not cleared, every entry is written before read.
// Stall  : coefficients wait in an output register and a skid register; memory
//          reads pause until there is room. Once the last read of a frame is
//          issued, samples of the next frame are taken while the tail drains.
`include "walsh_hadamard_transform_assert.svh"

module walsh_hadamard_transform #(
    parameter int SIZE        = 64,
    parameter int SAMPLE_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    wht_cfg_if.sink     i_cfg,
    wht_smp_if.sink     i_smp,
    wht_coef_if.source  o_coef
);

    import wht_pkg::*;

    localparam int ADDR_BITS  = $clog2(SIZE);
    localparam int LEN_BITS   = $clog2(SIZE + 1);
    localparam int COEF_BITS  = SAMPLE_BITS + ADDR_BITS;
    localparam int IDX_BITS   = (ADDR_BITS > 1) ? ADDR_BITS - 1 : 1;
    localparam int BANK_DEPTH = (SIZE + 1) / 2;
    // P - 1 for the reset frame length of SIZE
    localparam logic [ADDR_BITS-1:0] RST_PMASK =
        ADDR_BITS'((1 << ($clog2(SIZE + 1) - 1)) - 1);

    // Storage map: address parity (xor of all bits) picks the bank, the
    // address without bit 0 is the row. The two legs of any butterfly differ
    // in exactly one bit, so they always sit in opposite banks.
    function automatic logic [IDX_BITS-1:0] f_idx(input logic [ADDR_BITS-1:0] addr);
        return IDX_BITS'(addr >> 1);
    endfunction

    t_state                r_state, n_state;
    logic [LEN_BITS-1:0]   r_len, r_fill, r_emit;
    logic [ADDR_BITS-1:0]  r_pmask;
    logic [ADDR_BITS-1:0]  r_a, r_h;
    logic                  r_pb_v;
    logic [ADDR_BITS-1:0]  r_pb_a, r_pb_b;
    logic                  r_pe_v, r_pe_bank, r_pe_last;
    logic                  r_out_v, r_out_last;
    logic [COEF_BITS-1:0]  r_out_coef;
    logic                  r_skid_v, r_skid_last;
    logic [COEF_BITS-1:0]  r_skid_coef;

    logic                  we    [2];
    logic [IDX_BITS-1:0]   waddr [2];
    logic [IDX_BITS-1:0]   raddr [2];
    logic [COEF_BITS-1:0]  wdata [2];
    logic [COEF_BITS-1:0]  rdata [2];

    logic                  smp_xfer, cfg_xfer, frame_done;
    logic                  stage_end, xform_done;
    logic                  pop, room, emit_issue, emit_last, emit_end;
    logic [ADDR_BITS-1:0]  fill_addr, emit_addr, b_addr;
    logic                  fill_bank, a_bank, pa_bank;
    logic [COEF_BITS-1:0]  smp_ext, va, vb, bf_sum, bf_diff, pe_data;
    logic [LEN_BITS-1:0]   cfg_eff, cfg_smear;
    logic [ADDR_BITS-1:0]  cfg_pmask;
    logic                  out_free, out_from_skid, out_from_push, skid_load;

    // Two memory banks hold the frame
    for (genvar k = 0; k < 2; k++) begin : g_bank
        wht_ram #(
            .WIDTH (COEF_BITS),
            .DEPTH (BANK_DEPTH)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (we[k]),
            .i_waddr (waddr[k]),
            .i_wdata (wdata[k]),
            .i_raddr (raddr[k]),
            .o_rdata (rdata[k])
        );
    end

    assign smp_xfer = i_smp.valid && i_smp.ready;
    assign cfg_xfer = i_cfg.valid && i_cfg.ready;

    // Configuration: clamp the length, then smear its top bit down to get P - 1
    always_comb begin
        if (i_cfg.frame_length == '0) begin
            cfg_eff = LEN_BITS'(1);
        end else if (i_cfg.frame_length > LEN_BITS'(SIZE)) begin
            cfg_eff = LEN_BITS'(SIZE);
        end else begin
            cfg_eff = i_cfg.frame_length;
        end
        cfg_smear = cfg_eff;
        for (int i = 1; i < LEN_BITS; i++) begin
            cfg_smear = cfg_smear | (cfg_eff >> i);
        end
    end
    assign cfg_pmask = ADDR_BITS'(cfg_smear >> 1);

    // Sample load
    assign fill_addr  = ADDR_BITS'(r_fill);
    assign fill_bank  = ^fill_addr;
    assign smp_ext    = {{ADDR_BITS{i_smp.sample[SAMPLE_BITS-1]}}, i_smp.sample};
    assign frame_done = smp_xfer && (r_fill == r_len - LEN_BITS'(1));

    // Butterfly walk: r_h is the one-hot span, r_a the upper-left leg with bit h clear
    assign b_addr     = r_a | r_h;
    assign a_bank     = ^r_a;
    assign stage_end  = (b_addr == r_pmask);
    assign xform_done = ((r_h & r_pmask) == '0);

    // Butterfly write-back, in the cycle after the reads
    assign pa_bank = ^r_pb_a;
    assign va      = pa_bank ? rdata[1] : rdata[0];
    assign vb      = pa_bank ? rdata[0] : rdata[1];
    assign bf_sum  = va + vb;
    assign bf_diff = va - vb;

    // Emit reads: issue only when the output register and skid can take the data
    assign pop        = r_out_v && o_coef.ready;
    assign room       = ({1'b0, r_out_v} + {1'b0, r_skid_v} + {1'b0, r_pe_v})
                        <= ({1'b0, pop} + 2'd1);
    assign emit_addr  = ADDR_BITS'(r_emit);
    assign emit_last  = (r_emit == r_len - LEN_BITS'(1));
    assign emit_issue = (r_state == ST_EMIT) && room;
    assign emit_end   = emit_issue && emit_last;
    assign pe_data    = r_pe_bank ? rdata[1] : rdata[0];

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_LOAD: begin
                if (frame_done) begin
                    n_state = (r_pmask == '0) ? ST_EMIT : ST_XFORM;
                end
            end
            ST_XFORM: begin
                if (stage_end) begin
                    n_state = ST_XGAP;
                end
            end
            ST_XGAP: begin
                n_state = xform_done ? ST_EMIT : ST_XFORM;
            end
            ST_EMIT: begin
                if (emit_end) begin
                    n_state = ST_LOAD;
                end
            end
        endcase
    end

    // Memory port steering
    always_comb begin
        for (int k = 0; k < 2; k++) begin
            we[k]    = 1'b0;
            waddr[k] = '0;
            wdata[k] = '0;
            raddr[k] = f_idx(emit_addr);
        end
        if (smp_xfer) begin
            we[fill_bank]    = 1'b1;
            waddr[fill_bank] = f_idx(fill_addr);
            wdata[fill_bank] = smp_ext;
        end
        if (r_pb_v) begin
            we[pa_bank]     = 1'b1;
            waddr[pa_bank]  = f_idx(r_pb_a);
            wdata[pa_bank]  = bf_sum;
            we[!pa_bank]    = 1'b1;
            waddr[!pa_bank] = f_idx(r_pb_b);
            wdata[!pa_bank] = bf_diff;
        end
        if (r_state == ST_XFORM) begin
            raddr[a_bank]  = f_idx(r_a);
            raddr[!a_bank] = f_idx(b_addr);
        end
    end

    // Output register and skid steering
    assign out_free      = !r_out_v || pop;
    assign out_from_skid = out_free && r_skid_v;
    assign out_from_push = out_free && !r_skid_v && r_pe_v;
    assign skid_load     = r_pe_v && !out_from_push;

    assign i_smp.ready        = (r_state == ST_LOAD);
    assign i_cfg.ready        = 1'b1;
    assign o_coef.valid       = r_out_v;
    assign o_coef.coefficient = $signed(r_out_coef);
    assign o_coef.last        = r_out_last;

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_LOAD;
            r_len    <= LEN_BITS'(SIZE);
            r_pmask  <= RST_PMASK;
            r_fill   <= '0;
            r_emit   <= '0;
            r_a      <= '0;
            r_h      <= ADDR_BITS'(1);
            r_pb_v   <= 1'b0;
            r_pe_v   <= 1'b0;
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            r_state <= n_state;
            // drop any partial frame on a length write
            if (cfg_xfer) begin
                r_len   <= cfg_eff;
                r_pmask <= cfg_pmask;
                r_fill  <= '0;
            end else if (smp_xfer) begin
                r_fill <= frame_done ? '0 : r_fill + LEN_BITS'(1);
            end
            // advance the butterfly walk, skipping over bit h
            if (r_state == ST_LOAD) begin
                r_a <= '0;
                r_h <= ADDR_BITS'(1);
            end else if (r_state == ST_XFORM) begin
                if (stage_end) begin
                    r_a <= '0;
                    r_h <= r_h << 1;
                end else begin
                    r_a <= (b_addr + ADDR_BITS'(1)) & ~r_h;
                end
            end
            if (r_state != ST_EMIT) begin
                r_emit <= '0;
            end else if (emit_issue) begin
                r_emit <= r_emit + LEN_BITS'(1);
            end
            r_pb_v   <= (r_state == ST_XFORM);
            r_pe_v   <= emit_issue;
            r_out_v  <= out_free ? (r_skid_v || r_pe_v) : 1'b1;
            r_skid_v <= skid_load ? 1'b1 : (out_from_skid ? 1'b0 : r_skid_v);
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        r_pb_a    <= r_a;
        r_pb_b    <= b_addr;
        r_pe_bank <= ^emit_addr;
        r_pe_last <= emit_last;
        if (out_from_skid) begin
            r_out_coef <= r_skid_coef;
            r_out_last <= r_skid_last;
        end else if (out_from_push) begin
            r_out_coef <= pe_data;
            r_out_last <= r_pe_last;
        end
        if (skid_load) begin
            r_skid_coef <= pe_data;
            r_skid_last <= r_pe_last;
        end
    end

    // Legs of a butterfly must land in different banks
    `WHT_ASSERT_IMP(a_bank_split, i_clk, i_rst_n, r_pb_v, (^r_pb_a) != (^r_pb_b),
        "butterfly legs share a bank")
    // A returning read must always find a free output slot
    `WHT_ASSERT_IMP(a_skid_room, i_clk, i_rst_n, r_pe_v && r_out_v && !o_coef.ready,
        !r_skid_v, "output read returned with no room")
    // Emit reads drain before the transform reuses the read ports
    `WHT_ASSERT_IMP(a_port_share, i_clk, i_rst_n, r_state == ST_XFORM, !r_pe_v,
        "emit read in flight during transform")
    // Fill count stays inside the frame
    `WHT_ASSERT_IMP(a_fill_range, i_clk, i_rst_n, 1'b1, r_fill < r_len,
        "fill count beyond frame length")
    // Every transform cycle issues a butterfly that writes back next cycle
    `WHT_ASSERT_NXT(a_bfly_wb, i_clk, i_rst_n, r_state == ST_XFORM, r_pb_v,
        "butterfly write-back missing")

endmodule
